// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bcr_pkg.sv
package bcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 8192;

    localparam int CORNER_W = 20;
    localparam int DIM_W    = 14;
    localparam int POS_W    = 13;
    localparam int MODEL_W  = 13;
    localparam int OFF_W    = 13;
    localparam int SCALE_W  = 24;
    localparam int NORM_W   = FRAC_BITS + 1;
    localparam int ABS_W    = 14;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    // Corner times model size plus the offset term.
    localparam int V_W    = CORNER_W + MODEL_W + 2;
    // Magnitude after the optional fraction shift.
    localparam int MAG1_W = V_W - 1 + FRAC_BITS;
    // Resize scale times ROI size.
    localparam int DEN1_W = SCALE_W + DIM_W;
    // Saturation limit of the restored corner is 1 << Q1_W.
    localparam int Q1_W   = FRAC_BITS + 24;
    localparam int M2_W   = Q1_W + 1;
    localparam int P3_W   = M2_W + DIM_W;
    localparam int N_W    = P3_W + 1;
    localparam int Q2_W   = NORM_W;
    localparam int NUM2_W = Q2_W + DIM_W;
    localparam int PA_W   = NORM_W + DIM_W;
    localparam int LEN_W  = NORM_W + DIM_W + 2;

    typedef enum logic [2:0] {
        REG_MODEL_W,
        REG_MODEL_H,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_FRAME_W,
        REG_FRAME_H
    } reg_idx_t;

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic             inr;
        logic [POS_W-1:0] rpos;
        logic [DIM_W-1:0] rsize;
    } side1_t;

    typedef struct packed {
        logic neg;
        logic sat;
    } side2_t;

    // Frame size as used by the arithmetic: saturated into [1, MAX_DIM].
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

// File: rtl/bcr_in_if.sv
interface bcr_in_if;
    import bcr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [CORNER_W-1:0] in_x_min;
    logic signed [CORNER_W-1:0] in_y_min;
    logic signed [CORNER_W-1:0] in_x_max;
    logic signed [CORNER_W-1:0] in_y_max;
    logic [DIM_W-1:0]           roi_width;
    logic [DIM_W-1:0]           roi_height;
    logic                       transformed;
    logic                       in_region;
    logic [POS_W-1:0]           region_x;
    logic [POS_W-1:0]           region_y;
    logic [DIM_W-1:0]           region_w;
    logic [DIM_W-1:0]           region_h;

    modport source (
        output valid, in_x_min, in_y_min, in_x_max, in_y_max, roi_width, roi_height,
               transformed, in_region, region_x, region_y, region_w, region_h,
        input  ready
    );

    modport sink (
        input  valid, in_x_min, in_y_min, in_x_max, in_y_max, roi_width, roi_height,
               transformed, in_region, region_x, region_y, region_w, region_h,
        output ready
    );
endinterface

// File: rtl/bcr_out_if.sv
interface bcr_out_if;
    import bcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [NORM_W-1:0] out_x_min;
    logic [NORM_W-1:0] out_y_min;
    logic [NORM_W-1:0] out_x_max;
    logic [NORM_W-1:0] out_y_max;
    logic [ABS_W-1:0]  abs_left;
    logic [ABS_W-1:0]  abs_top;
    logic [ABS_W-1:0]  abs_width;
    logic [ABS_W-1:0]  abs_height;

    modport source (
        output valid, out_x_min, out_y_min, out_x_max, out_y_max,
               abs_left, abs_top, abs_width, abs_height,
        input  ready
    );

    modport sink (
        input  valid, out_x_min, out_y_min, out_x_max, out_y_max,
               abs_left, abs_top, abs_width, abs_height,
        output ready
    );
endinterface

// File: rtl/bcr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The numerator must be below (den << QW); the quotient is then exact.
module bcr_div #(
    parameter int NW = 31,
    parameter int DW = 14,
    parameter int QW = 17,
    parameter int SW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] out_side
);
    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [QW];
    logic [W-1:0]  rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  dsh;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] sd_in;
        logic          v_in;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in = W'(num);
            assign q_in   = '0;
            assign d_in   = den;
            assign sd_in  = in_side;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = quo_reg[s-1];
            assign d_in   = den_reg[s-1];
            assign sd_in  = side_reg[s-1];
            assign v_in   = vld_reg[s-1];
        end

        assign dsh  = W'(d_in) << (QW - 1 - s);
        assign take = (rem_in >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= take ? (rem_in - dsh) : rem_in;
                quo_reg[s]  <= q_in | (QW'(take) << (QW - 1 - s));
                den_reg[s]  <= d_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];
endmodule

// File: rtl/bbox_coordinate_restore.sv
// Bounding-box coordinate restore.
// A box request arrives on din with four corners normalised to the model input
// (signed, 16 fraction bits) plus the ROI size and the parent-region geometry.
// One result request leaves on dout with the corners clamped to [0, 1] and the
// absolute left, top, width and height in frame pixels, rounded half up.
// Both channels use valid/ready; a request moves when both are high.
// The APB port holds the model size, offsets, resize scales and frame size;
// the user must see that they are written only while the block is empty, as
// the block itself does not enforce it. The pipeline takes one request every
// cycle while dout is not stalled. Most of its depth comes from two bit-per-stage
// dividers: 40 stages for the resize and ROI division and 17 stages for the
// division by the frame size.
// When dout is stalled the whole pipeline holds and din.ready drops in the same
// cycle, so nothing is lost or repeated; din.ready is high whenever the output
// register is empty or being emptied.
// Reset clears all valid bits and loads the registers with model and frame
// sizes of 1, zero offsets and zero scales.
module bbox_coordinate_restore (
    input  logic                  clk,
    input  logic                  rst_n,
    bcr_in_if.sink                din,
    bcr_out_if.source             dout,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [bcr_pkg::ADDR_W-1:0] paddr,
    input  logic [bcr_pkg::DATA_W-1:0] pwdata,
    output logic [bcr_pkg::DATA_W-1:0] prdata,
    output logic                  pready
);
    import bcr_pkg::*;

    // Configuration registers.
    logic [MODEL_W-1:0]      model_w_reg;
    logic [MODEL_W-1:0]      model_h_reg;
    logic signed [OFF_W-1:0] offset_x_reg;
    logic signed [OFF_W-1:0] offset_y_reg;
    logic [SCALE_W-1:0]      scale_x_reg;
    logic [SCALE_W-1:0]      scale_y_reg;
    logic [DIM_W-1:0]        frame_w_reg;
    logic [DIM_W-1:0]        frame_h_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_w_reg  <= MODEL_W'(1);
            model_h_reg  <= MODEL_W'(1);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            scale_x_reg  <= '0;
            scale_y_reg  <= '0;
            frame_w_reg  <= DIM_W'(1);
            frame_h_reg  <= DIM_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODEL_W:  model_w_reg  <= pwdata[MODEL_W-1:0];
                REG_MODEL_H:  model_h_reg  <= pwdata[MODEL_W-1:0];
                REG_OFFSET_X: offset_x_reg <= $signed(pwdata[OFF_W-1:0]);
                REG_OFFSET_Y: offset_y_reg <= $signed(pwdata[OFF_W-1:0]);
                REG_SCALE_X:  scale_x_reg  <= pwdata[SCALE_W-1:0];
                REG_SCALE_Y:  scale_y_reg  <= pwdata[SCALE_W-1:0];
                REG_FRAME_W:  frame_w_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_H:  frame_h_reg  <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODEL_W:  prdata = DATA_W'(model_w_reg);
            REG_MODEL_H:  prdata = DATA_W'(model_h_reg);
            REG_OFFSET_X: prdata = DATA_W'($unsigned(offset_x_reg));
            REG_OFFSET_Y: prdata = DATA_W'($unsigned(offset_y_reg));
            REG_SCALE_X:  prdata = DATA_W'(scale_x_reg);
            REG_SCALE_Y:  prdata = DATA_W'(scale_y_reg);
            REG_FRAME_W:  prdata = DATA_W'(frame_w_reg);
            REG_FRAME_H:  prdata = DATA_W'(frame_h_reg);
            default:      prdata = '0;
        endcase
    end

    // Per-axis views: index 0 is horizontal, index 1 vertical. Corners 0 and 2
    // are on the horizontal axis, corners 1 and 3 on the vertical one.
    logic [MODEL_W-1:0]         model_ax [2];
    logic signed [OFF_W-1:0]    off_ax   [2];
    logic [SCALE_W-1:0]         scale_ax [2];
    logic [DIM_W-1:0]           fdim_ax  [2];
    logic [DIM_W-1:0]           roi_ax   [2];
    logic [POS_W-1:0]           rpos_ax  [2];
    logic [DIM_W-1:0]           rsize_ax [2];
    logic signed [CORNER_W-1:0] cin      [4];

    always_comb
    begin
        model_ax[0] = model_w_reg;
        model_ax[1] = model_h_reg;
        off_ax[0]   = offset_x_reg;
        off_ax[1]   = offset_y_reg;
        scale_ax[0] = scale_x_reg;
        scale_ax[1] = scale_y_reg;
        fdim_ax[0]  = eff_dim(frame_w_reg);
        fdim_ax[1]  = eff_dim(frame_h_reg);
        roi_ax[0]   = din.roi_width;
        roi_ax[1]   = din.roi_height;
        rpos_ax[0]  = din.region_x;
        rpos_ax[1]  = din.region_y;
        rsize_ax[0] = din.region_w;
        rsize_ax[1] = din.region_h;
        cin[0]      = din.in_x_min;
        cin[1]      = din.in_y_min;
        cin[2]      = din.in_x_max;
        cin[3]      = din.in_y_max;
    end

    // The whole pipeline advances together whenever the output register can
    // take a new result.
    logic en;
    logic dout_valid_reg;

    assign en        = !dout_valid_reg || dout.ready;
    assign din.ready = en;

    // Stage 1: corner times model size, and the combined divisor (resize scale
    // times ROI size, each taken as 1 when zero, or 1 when no transform is undone).
    logic                     s1_vld_reg;
    logic                     s1_tr_reg;
    logic                     s1_inr_reg;
    logic signed [V_W-1:0]    s1_prod_reg  [4];
    logic [DEN1_W-1:0]        s1_den_reg   [2];
    logic                     s1_shift_reg [2];
    logic [POS_W-1:0]         s1_rpos_reg  [2];
    logic [DIM_W-1:0]         s1_rsize_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tr_reg  <= din.transformed;
            s1_inr_reg <= din.in_region;
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_axis1
        logic [SCALE_W-1:0] sc_eff;
        logic [DIM_W-1:0]   roi_eff;

        assign sc_eff  = (scale_ax[a] == '0) ? SCALE_W'(1) : scale_ax[a];
        assign roi_eff = (roi_ax[a] == '0) ? DIM_W'(1) : roi_ax[a];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_den_reg[a]   <= din.transformed ? DEN1_W'(sc_eff) * DEN1_W'(roi_eff)
                                                   : DEN1_W'(1);
                s1_shift_reg[a] <= din.transformed && (scale_ax[a] != '0);
                s1_rpos_reg[a]  <= rpos_ax[a];
                s1_rsize_reg[a] <= rsize_ax[a];
            end
        end
    end

    // Stage 2 to the end of the second divider, one lane per corner.
    logic                     s2_vld_reg;
    logic [MAG1_W-1:0]        s2_num_reg  [4];
    logic [DEN1_W-1:0]        s2_den_reg  [4];
    side1_t                   s2_side_reg [4];
    logic [Q1_W-1:0]          d1_q        [4];
    side1_t                   d1_side     [4];
    logic                     d1_vld;
    logic                     s3_vld_reg;
    logic [P3_W-1:0]          s3_prod_reg [4];
    logic [M2_W-1:0]          s3_mag_reg  [4];
    logic                     s3_neg_reg  [4];
    logic                     s3_inr_reg  [4];
    logic [POS_W-1:0]         s3_rpos_reg [4];
    logic                     s4_vld_reg;
    logic [NUM2_W-1:0]        s4_num_reg  [4];
    logic [DIM_W-1:0]         s4_den_reg  [4];
    side2_t                   s4_side_reg [4];
    logic [Q2_W-1:0]          d2_q        [4];
    side2_t                   d2_side     [4];
    logic                     d2_vld;
    logic                     s5_vld_reg;
    logic [NORM_W-1:0]        s5_cr_reg   [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= d1_vld;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= d2_vld;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_corner
        localparam int AX = i % 2;

        logic signed [V_W-1:0] v;
        logic                  v_neg;
        logic [V_W-1:0]        v_abs;
        logic [MAG1_W-1:0]     mag1;
        logic                  sat1;
        side1_t                sd1;
        logic [M2_W-1:0]       mag2;
        logic [N_W-1:0]        pa;
        logic [N_W-1:0]        pp;
        logic                  n_neg;
        logic [N_W-1:0]        n_mag;
        logic [DIM_W-1:0]      fdiv;
        logic                  sat2;
        logic [NORM_W-1:0]     cr;
        logic                  vld_unused1;
        logic                  vld_unused2;

        // Stage 1: the corner is scaled by the model size only when the
        // transform is undone; otherwise it passes through unchanged.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_prod_reg[i] <= din.transformed
                                  ? $signed(V_W'(cin[i])) * $signed(V_W'(model_ax[AX]))
                                  : V_W'(cin[i]);
            end
        end

        // Stage 2: add the offset if the transform is undone, take the magnitude,
        // apply the fraction shift of the resize division, spot saturating quotients.
        always_comb
        begin
            v = s1_tr_reg ? (s1_prod_reg[i] + (V_W'(off_ax[AX]) <<< FRAC_BITS))
                          : s1_prod_reg[i];
            v_neg = v[V_W-1];
            v_abs = v_neg ? V_W'(-v) : V_W'(v);
            mag1  = s1_shift_reg[AX] ? {v_abs[V_W-2:0], FRAC_BITS'(0)}
                                     : MAG1_W'(v_abs[V_W-2:0]);
            sat1  = (mag1 >> Q1_W) >= MAG1_W'(s1_den_reg[AX]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_num_reg[i]        <= sat1 ? '0 : mag1;
                s2_den_reg[i]        <= s1_den_reg[AX];
                s2_side_reg[i].neg   <= v_neg;
                s2_side_reg[i].sat   <= sat1;
                s2_side_reg[i].inr   <= s1_inr_reg;
                s2_side_reg[i].rpos  <= s1_rpos_reg[AX];
                s2_side_reg[i].rsize <= s1_rsize_reg[AX];
            end
        end

        bcr_div #(
            .NW (MAG1_W),
            .DW (DEN1_W),
            .QW (Q1_W),
            .SW ($bits(side1_t))
        ) u_div1 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s2_vld_reg),
            .num       (s2_num_reg[i]),
            .den       (s2_den_reg[i]),
            .in_side   (s2_side_reg[i]),
            .out_valid (vld_unused1),
            .quo       (d1_q[i]),
            .out_side  (d1_side[i])
        );

        // Stage 3: parent-region size times the restored magnitude.
        always_comb
        begin
            sd1  = d1_side[i];
            mag2 = sd1.sat ? (M2_W'(1) << Q1_W) : M2_W'(d1_q[i]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s3_prod_reg[i] <= P3_W'(sd1.rsize) * P3_W'(mag2);
                s3_mag_reg[i]  <= mag2;
                s3_neg_reg[i]  <= sd1.neg;
                s3_inr_reg[i]  <= sd1.inr;
                s3_rpos_reg[i] <= sd1.rpos;
            end
        end

        // Stage 4: add the region origin with the corner's sign and pick the
        // divisor. Without a parent region the corner passes with divisor 1.
        always_comb
        begin
            pa   = N_W'(s3_rpos_reg[i]) << FRAC_BITS;
            pp   = N_W'(s3_prod_reg[i]);
            fdiv = fdim_ax[AX];
            if (!s3_inr_reg[i])
            begin
                n_neg = s3_neg_reg[i];
                n_mag = N_W'(s3_mag_reg[i]);
                fdiv  = DIM_W'(1);
            end
            else if (!s3_neg_reg[i])
            begin
                n_neg = 1'b0;
                n_mag = pa + pp;
            end
            else if (pa >= pp)
            begin
                n_neg = 1'b0;
                n_mag = pa - pp;
            end
            else
            begin
                n_neg = 1'b1;
                n_mag = pp - pa;
            end
            sat2 = (n_mag >> Q2_W) >= N_W'(fdiv);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s4_num_reg[i]      <= sat2 ? '0 : n_mag[NUM2_W-1:0];
                s4_den_reg[i]      <= fdiv;
                s4_side_reg[i].neg <= n_neg;
                s4_side_reg[i].sat <= sat2;
            end
        end

        bcr_div #(
            .NW (NUM2_W),
            .DW (DIM_W),
            .QW (Q2_W),
            .SW ($bits(side2_t))
        ) u_div2 (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s4_vld_reg),
            .num       (s4_num_reg[i]),
            .den       (s4_den_reg[i]),
            .in_side   (s4_side_reg[i]),
            .out_valid (vld_unused2),
            .quo       (d2_q[i]),
            .out_side  (d2_side[i])
        );

        // Stage 5: clamp into [0, 1]. A negative quotient truncates to zero or
        // below, so it always clamps to zero.
        always_comb
        begin
            if (d2_side[i].neg)
            begin
                cr = '0;
            end
            else if (d2_side[i].sat || (d2_q[i] > (NORM_W'(1) << FRAC_BITS)))
            begin
                cr = NORM_W'(1) << FRAC_BITS;
            end
            else
            begin
                cr = d2_q[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s5_cr_reg[i] <= cr;
            end
        end

        if (i == 0)
        begin : g_vld
            assign d1_vld = vld_unused1;
            assign d2_vld = vld_unused2;
        end
    end

    // Stage 6: absolute position and extent products.
    logic                    s6_vld_reg;
    logic [NORM_W-1:0]       s6_cr_reg  [4];
    logic [PA_W-1:0]         s6_pos_reg [2];
    logic signed [LEN_W-1:0] s6_len_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_axis6
        logic signed [NORM_W:0] diff;

        assign diff = $signed({1'b0, s5_cr_reg[a+2]}) - $signed({1'b0, s5_cr_reg[a]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s6_cr_reg[a]   <= s5_cr_reg[a];
                s6_cr_reg[a+2] <= s5_cr_reg[a+2];
                s6_pos_reg[a]  <= PA_W'(s5_cr_reg[a]) * PA_W'(fdim_ax[a]);
                s6_len_reg[a]  <= LEN_W'(diff) * LEN_W'($signed({1'b0, fdim_ax[a]}));
            end
        end
    end

    // Stage 7: round half up and fill the output register.
    logic [PA_W-1:0]         pos_rnd [2];
    logic signed [LEN_W-1:0] len_rnd [2];
    logic [ABS_W-1:0]        pos_abs [2];
    logic [ABS_W-1:0]        len_abs [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            pos_rnd[a] = s6_pos_reg[a] + (PA_W'(1) << (FRAC_BITS - 1));
            len_rnd[a] = s6_len_reg[a] + (LEN_W'(1) <<< (FRAC_BITS - 1));
            pos_abs[a] = pos_rnd[a][FRAC_BITS+ABS_W-1:FRAC_BITS];
            len_abs[a] = len_rnd[a][LEN_W-1] ? '0 : len_rnd[a][FRAC_BITS+ABS_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dout_valid_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout.out_x_min  <= s6_cr_reg[0];
            dout.out_y_min  <= s6_cr_reg[1];
            dout.out_x_max  <= s6_cr_reg[2];
            dout.out_y_max  <= s6_cr_reg[3];
            dout.abs_left   <= pos_abs[0];
            dout.abs_top    <= pos_abs[1];
            dout.abs_width  <= len_abs[0];
            dout.abs_height <= len_abs[1];
        end
    end

    assign dout.valid = dout_valid_reg;
endmodule

// File: rtl/bcr_checker.sv
`include "assert_macros.svh"

module bcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_x_min,
    input logic [16:0] out_x_max,
    input logic [13:0] abs_width
);
    // The input side is held exactly while a finished result waits.
    `ASSERT_CLK(a_ready_tracks_stall, in_ready == (!out_valid || out_ready), "in_ready does not follow the output stall")

    // A waiting result stays and keeps its value.
    `ASSERT_CLK(a_hold_on_stall, out_valid && !out_ready |=> out_valid && $stable(out_x_min) && $stable(abs_width), "result changed while stalled")

    // Clamped corners never exceed one and the width never exceeds 8192 pixels.
    `ASSERT_CLK(a_out_range, out_valid |-> out_x_min <= 17'h10000 && out_x_max <= 17'h10000 && abs_width <= 14'd8192, "result out of range")

    // No result appears straight out of reset.
    `ASSERT_CLK_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind bbox_coordinate_restore bcr_checker u_bcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_x_min (dout.out_x_min),
    .out_x_max (dout.out_x_max),
    .abs_width (dout.abs_width)
);
